// ===== sv/first_fit_free_list_allocator_defines.svh =====
// Assertion macros for the first-fit free-list allocator.
// Expects clk and rst_n in the scope of each use.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ffa same-cycle check failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ffa next-cycle check failed");

`endif

// ===== sv/ffa_pkg.sv =====
// Shared types and constants of the first-fit free-list allocator.
// No dependencies.
`default_nettype none

package ffa_pkg;

    localparam int HEAP_UNITS_MAX_DEF = 4096;
    localparam int UNIT_BYTES_DEF     = 16;
    localparam int HEAP_CFG_W         = 13;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [23:0] request_bytes;
        logic [12:0] block_unit;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] payload_unit;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/ffa_mem.sv =====
// Header store: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module ffa_mem #(
    parameter int AW = 12,
    parameter int DW = 25
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ffa_ctrl.sv =====
// Sequencer of the allocator: clearing pass, list walks, split, insert and merge.
// Uses ffa_pkg and drives the header store ffa_mem.
`default_nettype none

module ffa_ctrl
    import ffa_pkg::*;
#(
    parameter int HEAP_UNITS_MAX = HEAP_UNITS_MAX_DEF,
    parameter int UNIT_BYTES     = UNIT_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [HEAP_CFG_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output res_t                       res,
    input  wire logic                  res_take
);

    localparam int AW     = $clog2(HEAP_UNITS_MAX);
    localparam int SW     = AW + 1;
    localparam int DW     = AW + SW;
    localparam int SH     = $clog2(UNIT_BYTES);
    localparam int NEED_W = 24 - SH + 2;
    localparam int STW    = AW + 2;
    localparam int HU_RST = (HEAP_UNITS_MAX < 4096) ? HEAP_UNITS_MAX : 4096;

    typedef struct packed {
        logic [AW-1:0] nxt;
        logic [SW-1:0] size;
    } row_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_PREV, S_A_WALK, S_A_TAIL,
        S_F_HDR, S_F_WALK, S_F_NX, S_F_CUR, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [SW-1:0]     heap_units_reg, heap_units_next;
    logic [AW-1:0]     rover_reg, rover_next;
    logic              empty_reg, empty_next;
    logic [AW:0]       clr_reg, clr_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [AW-1:0]     h_reg, h_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [AW-1:0]     prev_reg, prev_next;
    logic [SW-1:0]     psize_reg, psize_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [SW-1:0]     csize_reg, csize_next;
    logic [AW-1:0]     nx_reg, nx_next;
    logic [STW-1:0]    steps_reg, steps_next;
    status_t           status_reg, status_next;
    logic [11:0]       pay_reg, pay_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    row_t          mem_wrow;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    row_t          rrow;

    logic [12:0]   hv;
    logic [SW-1:0] newsize;
    logic [SW:0]   h_end;
    logic [SW:0]   c_end;
    logic          placed;
    int            cfg_v;

    assign rrow = row_t'(mem_rdata);

    ffa_mem #(.AW(AW), .DW(DW)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(DW'(mem_wrow)),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign in_stall       = (state_reg != S_IDLE);
    assign res.valid      = (state_reg == S_DONE);
    assign res.item       = '{status: status_reg, payload_unit: pay_reg};

    always_comb
    begin
        state_next      = state_reg;
        heap_units_next = heap_units_reg;
        rover_next      = rover_reg;
        empty_next      = empty_reg;
        clr_next        = clr_reg;
        need_next       = need_reg;
        h_next          = h_reg;
        s_next          = s_reg;
        prev_next       = prev_reg;
        psize_next      = psize_reg;
        cur_next        = cur_reg;
        csize_next      = csize_reg;
        nx_next         = nx_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        pay_next        = pay_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wrow        = '{nxt: rrow.nxt, size: rrow.size};
        mem_raddr       = cur_reg;
        hv              = in_item.block_unit - 13'd1;
        newsize         = rrow.size - need_reg[SW-1:0];
        h_end           = (SW+1)'(h_reg) + (SW+1)'(s_reg);
        c_end           = (SW+1)'(cur_reg) + (SW+1)'(rrow.size);
        placed          = 1'b0;
        cfg_v           = int'(cfg_data);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wrow  = '{nxt: '0, size: (clr_reg == '0) ? heap_units_reg : '0};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'((1 << AW) - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pay_next = '0;
                    if (in_item.op == OP_ALLOC)
                    begin
                        need_next = NEED_W'((in_item.request_bytes + 24'(UNIT_BYTES - 1))
                                    >> SH) + 1'b1;
                        // carry of the rounding add
                        if ((25'(in_item.request_bytes) + 25'(UNIT_BYTES - 1)) >> 24 != '0)
                        begin
                            need_next = NEED_W'(((25'(in_item.request_bytes)
                                        + 25'(UNIT_BYTES - 1)) >> SH) + 1);
                        end
                        if (empty_reg)
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            prev_next  = rover_reg;
                            mem_raddr  = rover_reg;
                            state_next = S_A_PREV;
                        end
                    end
                    else if (in_item.block_unit == '0 ||
                             32'(hv) >= 32'(heap_units_reg))
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        h_next     = AW'(hv);
                        mem_raddr  = AW'(hv);
                        state_next = S_F_HDR;
                    end
                end
            end
            S_A_PREV:
            begin
                psize_next = rrow.size;
                cur_next   = rrow.nxt;
                mem_raddr  = rrow.nxt;
                steps_next = '0;
                state_next = S_A_WALK;
            end
            S_A_WALK:
            begin
                if (NEED_W'(rrow.size) >= need_reg)
                begin
                    status_next = ST_ALLOC;
                    pay_next    = 12'(cur_reg + 1'b1);
                    state_next  = S_DONE;
                    if (NEED_W'(rrow.size) == need_reg)
                    begin
                        if (cur_reg == prev_reg)
                        begin
                            empty_next = 1'b1;
                            rover_next = '0;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = prev_reg;
                            mem_wrow   = '{nxt: rrow.nxt, size: psize_reg};
                            rover_next = prev_reg;
                        end
                    end
                    else
                    begin
                        // shrink in place, hand out the tail
                        mem_we     = 1'b1;
                        mem_waddr  = cur_reg;
                        mem_wrow   = '{nxt: rrow.nxt, size: newsize};
                        cur_next   = AW'(cur_reg + newsize);
                        rover_next = prev_reg;
                        state_next = S_A_TAIL;
                    end
                end
                else if (cur_reg == rover_reg ||
                         steps_reg == STW'(HEAP_UNITS_MAX))
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    psize_next = rrow.size;
                    cur_next   = rrow.nxt;
                    mem_raddr  = rrow.nxt;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_A_TAIL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = cur_reg;
                mem_wrow    = '{nxt: '0, size: need_reg[SW-1:0]};
                pay_next    = 12'(cur_reg + 1'b1);
                status_next = ST_ALLOC;
                state_next  = S_DONE;
            end
            S_F_HDR:
            begin
                s_next = rrow.size;
                if (rrow.size == '0 ||
                    (SW+1)'(h_reg) + (SW+1)'(rrow.size) > (SW+1)'(heap_units_reg))
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else if (empty_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = h_reg;
                    mem_wrow    = '{nxt: h_reg, size: rrow.size};
                    rover_next  = h_reg;
                    empty_next  = 1'b0;
                    status_next = ST_FREED;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = rover_reg;
                    mem_raddr  = rover_reg;
                    steps_next = '0;
                    state_next = S_F_WALK;
                end
            end
            S_F_WALK:
            begin
                if (h_reg > cur_reg && h_reg < rrow.nxt)
                begin
                    placed = 1'b1;
                end
                else if (h_reg == cur_reg || h_reg == rrow.nxt)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else if (cur_reg >= rrow.nxt && (h_reg > cur_reg || h_reg < rrow.nxt))
                begin
                    placed = 1'b1;  // list wrap point
                end
                else if (steps_reg == STW'(HEAP_UNITS_MAX))
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = rrow.nxt;
                    mem_raddr  = rrow.nxt;
                    steps_next = steps_reg + 1'b1;
                end
                if (placed)
                begin
                    if ((h_reg > cur_reg && c_end > (SW+1)'(h_reg)) ||
                        (h_reg < rrow.nxt && h_end > (SW+1)'(rrow.nxt)))
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        nx_next    = rrow.nxt;
                        csize_next = rrow.size;
                        mem_raddr  = rrow.nxt;
                        state_next = S_F_NX;
                    end
                end
            end
            S_F_NX:
            begin
                state_next = S_F_CUR;
                if (h_end == (SW+1)'(nx_reg))
                begin
                    if (nx_reg == cur_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = h_reg;
                        mem_wrow    = '{nxt: h_reg, size: s_reg + csize_reg};
                        rover_next  = h_reg;
                        status_next = ST_FREED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        s_next  = s_reg + rrow.size;
                        nx_next = rrow.nxt;
                    end
                end
                if (state_next == S_F_CUR)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = h_reg;
                    mem_wrow  = '{nxt: nx_next, size: s_next};
                end
            end
            S_F_CUR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                if ((SW+1)'(cur_reg) + (SW+1)'(csize_reg) == (SW+1)'(h_reg))
                begin
                    mem_wrow = '{nxt: nx_reg, size: csize_reg + s_reg};
                end
                else
                begin
                    mem_wrow = '{nxt: h_reg, size: csize_reg};
                end
                rover_next  = cur_reg;
                status_next = ST_FREED;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a heap size write restarts the heap from any state
        if (cfg_valid)
        begin
            if (cfg_v < 2)
            begin
                heap_units_next = SW'(2);
            end
            else if (cfg_v > HEAP_UNITS_MAX)
            begin
                heap_units_next = SW'(HEAP_UNITS_MAX);
            end
            else
            begin
                heap_units_next = SW'(cfg_v);
            end
            clr_next   = '0;
            rover_next = '0;
            empty_next = 1'b0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            heap_units_reg <= SW'(HU_RST);
            rover_reg      <= '0;
            empty_reg      <= 1'b0;
            clr_reg        <= '0;
            status_reg     <= ST_NOFIT;
            pay_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_units_reg <= heap_units_next;
            rover_reg      <= rover_next;
            empty_reg      <= empty_next;
            clr_reg        <= clr_next;
            status_reg     <= status_next;
            pay_reg        <= pay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg  <= need_next;
        h_reg     <= h_next;
        s_reg     <= s_next;
        prev_reg  <= prev_next;
        psize_reg <= psize_next;
        cur_reg   <= cur_next;
        csize_reg <= csize_next;
        nx_reg    <= nx_next;
        steps_reg <= steps_next;
    end

endmodule

`default_nettype wire

// ===== sv/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator: a single item is processed at a time.
//
// Input channel in_valid/in_stall carries one request item (allocate or free).
// Output channel out_valid/out_stall carries one result item per request.
// Config channel cfg_valid/cfg_ready writes heap_units and restarts the heap.
//
// Allocate and free walk the free list; the walk reads one header per
// cycle from the single read port of the header store.
// After reset, and after every heap_units write, a clearing pass writes one
// header per cycle over the whole header store; in_stall stays high meanwhile.
// The result sits in an output register; a stalled result holds, and the
// next request is taken only once the result has left the sequencer.
// Depends on ffa_pkg, ffa_ctrl, ffa_mem and the assertion macro header.
`default_nettype none
`include "first_fit_free_list_allocator_defines.svh"

module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_UNITS_MAX = HEAP_UNITS_MAX_DEF,
    parameter int UNIT_BYTES     = UNIT_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [HEAP_CFG_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item
);

    res_t      res;
    logic      res_take;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    assign cfg_ready = 1'b1;
    assign res_take  = res.valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    ffa_ctrl #(
        .HEAP_UNITS_MAX(HEAP_UNITS_MAX),
        .UNIT_BYTES    (UNIT_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .res      (res),
        .res_take (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_item_reg <= res.item;
        end
    end

    `FFA_ASSERT_IMP(a_pay_zero, out_valid && out_item.status != ST_ALLOC, out_item.payload_unit == 12'd0)
    `FFA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall && !cfg_valid, in_stall)
    `FFA_ASSERT_NXT(a_result_lands, res_take, out_valid)

endmodule

`default_nettype wire

// ===== sim/tb_first_fit_free_list_allocator.sv =====
// Self-checking testbench for first_fit_free_list_allocator: allocate/free traffic
// checked item by item against an in-bench free-list model, over several heap sizes.
// Depends on ffa_pkg and the allocator RTL.
`default_nettype none

module tb_first_fit_free_list_allocator;
    import ffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HMAX       = HEAP_UNITS_MAX_DEF;
    localparam int UNIT       = UNIT_BYTES_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [HEAP_CFG_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;

    first_fit_free_list_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // free-list model state
    int unsigned hdr_next [HMAX];
    int unsigned hdr_size [HMAX];
    int unsigned rover;
    int unsigned heap_units;
    bit          list_empty;

    in_item_t    req_q [$];
    out_item_t   expected_q [$];
    int unsigned live_q [$];
    int unsigned freed_q [$];

    int          mismatches;
    int          n_items, n_results, n_allocs, n_frees, n_cfg;
    int          cycles;
    bit          in_busy_mode, out_busy_mode;
    int          in_gap, stall_cnt;
    bit          cfg_pending;
    logic [HEAP_CFG_W-1:0] cfg_value;

    function automatic void heap_restart();
        for (int i = 0; i < HMAX; i++) begin
            hdr_next[i] = 0;
            hdr_size[i] = 0;
        end
        hdr_size[0] = heap_units;
        rover = 0;
        list_empty = 0;
    endfunction

    function automatic void heap_write(logic [HEAP_CFG_W-1:0] v);
        int unsigned u;
        u = v;
        if (u < 2) u = 2;
        if (u > HMAX) u = HMAX;
        heap_units = u;
        heap_restart();
    endfunction

    function automatic out_item_t alloc_predict(logic [23:0] bytes);
        longint unsigned need;
        int unsigned     prv, cur;
        out_item_t       r;
        r.status = ST_NOFIT;
        r.payload_unit = '0;
        if (list_empty) return r;
        need = (longint'(bytes) + UNIT - 1) / UNIT + 1;
        prv = rover;
        cur = hdr_next[prv];
        for (int steps = 0; steps <= HMAX; steps++) begin
            if (hdr_size[cur] >= need) begin
                if (hdr_size[cur] == need) begin
                    if (cur == prv) begin
                        list_empty = 1;
                        rover = 0;
                    end else begin
                        hdr_next[prv] = hdr_next[cur];
                        rover = prv;
                    end
                end else begin
                    // keep the head, hand out the tail
                    hdr_size[cur] = hdr_size[cur] - int'(need);
                    cur = cur + hdr_size[cur];
                    hdr_size[cur] = int'(need);
                    rover = prv;
                end
                r.status = ST_ALLOC;
                r.payload_unit = 12'(cur + 1);
                return r;
            end
            if (cur == rover) return r;
            prv = cur;
            cur = hdr_next[cur];
        end
        return r;
    endfunction

    function automatic status_t free_predict(logic [12:0] unit);
        int unsigned h, s, cur, nx;
        bit          placed;
        placed = 0;
        if (unit == 0) return ST_IGNORED;
        h = unit - 1;
        if (h >= heap_units) return ST_IGNORED;
        s = hdr_size[h];
        if (s == 0 || h + s > heap_units) return ST_IGNORED;
        if (list_empty) begin
            hdr_next[h] = h;
            rover = h;
            list_empty = 0;
            return ST_FREED;
        end
        cur = rover;
        nx = hdr_next[cur];
        for (int steps = 0; steps <= HMAX; steps++) begin
            nx = hdr_next[cur];
            if (h > cur && h < nx) begin
                placed = 1;
                break;
            end
            if (h == cur || h == nx) return ST_IGNORED;
            // wrap point of the circular list
            if (cur >= nx && (h > cur || h < nx)) begin
                placed = 1;
                break;
            end
            cur = nx;
        end
        if (!placed) return ST_IGNORED;
        if ((h > cur && cur + hdr_size[cur] > h) || (h < nx && h + s > nx))
            return ST_IGNORED;
        if (h + s == nx) begin
            if (nx == cur) begin
                hdr_size[h] = s + hdr_size[cur];
                hdr_next[h] = h;
                rover = h;
                return ST_FREED;
            end
            hdr_size[h] = s + hdr_size[nx];
            hdr_next[h] = hdr_next[nx];
        end else begin
            hdr_next[h] = nx;
        end
        if (cur + hdr_size[cur] == h) begin
            hdr_size[cur] = hdr_size[cur] + hdr_size[h];
            hdr_next[cur] = hdr_next[h];
        end else begin
            hdr_next[cur] = h;
        end
        rover = cur;
        return ST_FREED;
    endfunction

    function automatic int next_gap(bit busy);
        if (busy) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // request driver; prediction happens as each item is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_gap   = 0;
        end else begin
            if (in_valid && !in_stall) begin
                out_item_t r;
                n_items++;
                if (in_item.op == OP_ALLOC) begin
                    r = alloc_predict(in_item.request_bytes);
                    if (r.status == ST_ALLOC) live_q.push_back(r.payload_unit);
                    n_allocs++;
                end else begin
                    r.status = free_predict(in_item.block_unit);
                    r.payload_unit = '0;
                    if (r.status == ST_FREED) freed_q.push_back(in_item.block_unit);
                    n_frees++;
                end
                expected_q.push_back(r);
            end
            if (!in_valid || !in_stall) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    in_item  <= req_q.pop_front();
                    in_valid <= 1'b1;
                    in_gap   = next_gap(in_busy_mode);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // heap_units writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
            heap_write(cfg_data);
            live_q.delete();
            freed_q.delete();
            cfg_pending = 0;
            n_cfg++;
        end else if (cfg_pending && !cfg_valid) begin
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_value;
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d unit %0d",
                                 out_item.status, out_item.payload_unit);
                end else begin
                    out_item_t e;
                    e = expected_q.pop_front();
                    if (out_item.status !== e.status ||
                        out_item.payload_unit !== e.payload_unit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d unit %0d, got %0d unit %0d",
                                     e.status, e.payload_unit,
                                     out_item.status, out_item.payload_unit);
                    end
                end
            end
            if (stall_cnt != 0) begin
                stall_cnt--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (!out_busy_mode && $urandom_range(0, 3) == 0)
                    stall_cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                          : $urandom_range(8, 40);
            end
        end
    end

    task automatic send(op_t op, logic [23:0] bytes, logic [12:0] unit);
        in_item_t it;
        it.op = op;
        it.request_bytes = bytes;
        it.block_unit = unit;
        req_q.push_back(it);
        // wait until accepted so the live list reflects it
        do @(negedge clk); while (req_q.size() != 0 || in_valid);
    endtask

    task automatic drain();
        while (req_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        int unsigned idx, u;
        for (int i = 0; i < n; i++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (live_q.size() > 24) pick = pick / 2 + 50;
            if (pick < 50) begin
                if ($urandom_range(0, 29) == 0)
                    send(OP_ALLOC, 24'($urandom()), 13'($urandom()));
                else
                    send(OP_ALLOC, 24'($urandom_range(0, heap_units * UNIT / 6)),
                         13'($urandom()));
            end else if (pick < 82 && live_q.size() != 0) begin
                idx = $urandom_range(0, live_q.size() - 1);
                u = live_q[idx];
                live_q.delete(idx);
                send(OP_FREE, 24'($urandom()), 13'(u));
            end else if (pick < 88 && freed_q.size() != 0) begin
                // double free
                send(OP_FREE, 24'($urandom()),
                     13'(freed_q[$urandom_range(0, freed_q.size() - 1)]));
            end else if (pick < 93 && live_q.size() != 0) begin
                // pointer into the middle of a live block
                u = live_q[$urandom_range(0, live_q.size() - 1)] + $urandom_range(1, 3);
                send(OP_FREE, 24'($urandom()), 13'(u));
            end else begin
                send(OP_FREE, 24'($urandom()), 13'($urandom()));
            end
            if (freed_q.size() > 16) void'(freed_q.pop_front());
        end
    endtask

    initial
    begin
        logic [HEAP_CFG_W-1:0] settings [7];
        settings = '{13'd64, 13'd2, 13'd8191, 13'd0, 13'd1000, 13'd16, 13'd4096};
        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        n_items = 0;
        n_results = 0;
        n_allocs = 0;
        n_frees = 0;
        n_cfg = 0;
        cfg_pending = 0;
        cfg_value = '0;
        in_busy_mode = 0;
        out_busy_mode = 0;
        heap_units = HMAX;
        heap_restart();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // whole heap in one block, then empty-list behavior
        send(OP_ALLOC, 24'((HMAX - 1) * UNIT), '0);
        send(OP_ALLOC, 24'd0, '0);
        send(OP_FREE, 24'hFFFFFF, 13'd1);
        send(OP_FREE, '0, 13'd1);
        send(OP_FREE, '0, 13'd0);
        send(OP_FREE, '0, 13'd4097);
        send(OP_FREE, '0, 13'h1FFF);
        send(OP_ALLOC, 24'hFFFFFF, '0);
        send(OP_ALLOC, 24'd0, 13'h1FFF);
        send(OP_ALLOC, 24'd1, '0);
        send(OP_ALLOC, 24'd16, '0);
        send(OP_ALLOC, 24'd17, '0);
        send(OP_ALLOC, 24'd100, '0);
        // free out of order to hit both-side merges and overlap checks
        send(OP_FREE, '0, 13'(live_q[1] + 1));
        send(OP_FREE, '0, 13'(live_q[2]));
        send(OP_FREE, '0, 13'(live_q[3]));
        send(OP_FREE, '0, 13'(live_q[1]));
        send(OP_FREE, '0, 13'(live_q[4]));
        send(OP_FREE, '0, 13'(live_q[2]));
        send(OP_ALLOC, 24'((HMAX - 2) * UNIT), '0);
        live_q.delete();
        random_phase(80);

        for (int p = 0; p < 7; p++) begin
            drain();
            cfg_value = settings[p];
            cfg_pending = 1;
            while (cfg_pending) @(negedge clk);
            in_busy_mode = (p % 3 == 1);
            out_busy_mode = (p % 3 == 2);
            if (p == 1) begin
                // two-unit heap: one block, exact fit, then no room
                send(OP_ALLOC, 24'd16, '0);
                send(OP_ALLOC, 24'd0, '0);
                send(OP_FREE, '0, 13'd1);
                send(OP_FREE, '0, 13'd2);
            end
            random_phase(p == 1 ? 40 : 95);
        end
        drain();
        repeat (50) @(negedge clk);

        $display("covered %0d items (%0d allocate, %0d free), %0d results, %0d heap resizes",
                 n_items, n_allocs, n_frees, n_results, n_cfg);
        $display("mismatches: %0d, results still owed: %0d", mismatches, expected_q.size());
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
